[rtl/ras_pkg.sv]
// Package for the rational add/subtract/normalize block.
// Holds the item structs, action and status codes and the datapath command and status structs.
// No dependencies.
package ras_pkg;

    localparam logic [1:0] ACT_NORM = 2'd0;
    localparam logic [1:0] ACT_ADD  = 2'd1;
    localparam logic [1:0] ACT_SUB  = 2'd2;
    localparam logic [1:0] ACT_EQ   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] first_num;
        logic signed [31:0] first_den;
        logic signed [31:0] second_num;
        logic signed [31:0] second_den;
    } ras_in_t;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic [30:0]        result_den;
        logic               is_equal;
        logic [1:0]         status;
    } ras_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture operands, start first multiply
        logic mul2;      // second cross product
        logic mul3;      // denominator product
        logic combine;   // form numerator magnitude, start GCD
        logic gcd_step;  // one subtract-shift step of the GCD
        logic finish;    // load the divider: divisor GCD, both values
        logic div_step;  // one bit of both quotients
        logic emit;      // present the result
    } ras_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early;     // result known without reduction
        logic gcd_done;
        logic div_done;
    } ras_stat_t;

endpackage

[rtl/rational_add_sub_normalize.sv]
// Top level of the rational add/subtract/normalize block.
// Instantiates ras_ctrl and ras_dpath. Uses ras_pkg.
//
// Usage: drive the input item on in_item and raise start while busy is low;
// the transfer happens at that clock edge. busy stays high until the result
// has been shown. The result appears on out_item for exactly one cycle with
// done high; the receiver cannot stall and must take it then.
// Sequence: after the transfer the controller passes through the multiply,
// combine and GCD states. An item decided without reduction (zero
// denominator, equality test, zero result) then goes straight to the emit
// state; other items first run the binary GCD loop on the 2*WORD_BITS-bit
// products, then the one-bit-a-cycle divider for both quotients.
// The GCD loop and the divider take up most of the time for such items.
// One item is worked on at a time. Reset returns the controller to idle
// and clears done; no result is pending after reset.
module rational_add_sub_normalize
    import ras_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ras_in_t  in_item,
    output logic     busy,
    output logic     done,
    output ras_out_t out_item
);

    ras_cmd_t  cmd;
    ras_stat_t stat;

    ras_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ras_dpath #(.WORD_BITS(WORD_BITS)) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .stat     (stat),
        .strobe   (done),
        .out_item (out_item)
    );

endmodule

[rtl/ras_ctrl.sv]
// Controller state machine for the rational block.
// Sequences the datapath through multiply, GCD and division phases. Uses ras_pkg.
module ras_ctrl
    import ras_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ras_stat_t stat,
    output ras_cmd_t  cmd,
    output logic      busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL2 = 3'd1;
    localparam logic [2:0] S_MUL3 = 3'd2;
    localparam logic [2:0] S_COMB = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] state_reg, state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3 = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (stat.early)
                    state_next = S_EMIT;
                else if (stat.gcd_done)
                    state_next = S_FIN;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_EMIT;
                else
                    cmd.div_step = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/ras_dpath.sv]
// Datapath for the rational block: operand decode, one multiplier at load and one
// shared for the other two products, a binary GCD unit and a restoring divider for
// both quotients. Uses ras_pkg.
module ras_dpath
    import ras_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ras_in_t   in_item,
    input  ras_cmd_t  cmd,
    output ras_stat_t stat,
    output logic      strobe,
    output ras_out_t  out_item
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2 * WORD_BITS;
    localparam int CW = $clog2(MW + 1);

    // Operand magnitudes and signs.
    logic [W-1:0]  ma_reg, mb_reg, mc_reg, md_reg;
    logic          sa_reg, sc_reg, zero_reg;
    logic [1:0]    act_reg;
    logic [MW-1:0] p_reg, q_reg, den_reg, mag_reg;
    logic          neg_reg, early_reg;
    ras_out_t      early_out_reg;

    // GCD registers: binary GCD with common power-of-two count.
    logic [MW-1:0] gx_reg, gy_reg;
    logic [CW-1:0] gk_reg;

    // Divider registers: both quotients share one bit counter.
    logic [MW-1:0] dv_reg, qn_reg, qd_reg, rn_reg, rd_reg;
    logic [CW-1:0] dcnt_reg;

    logic          strobe_reg;
    ras_out_t      out_reg;

    // Decode of the incoming words from their low WORD_BITS bits.
    logic signed [W-1:0] a_w, b_w, c_w, d_w;
    logic [W-1:0]        ma_w, mb_w, mc_w, md_w;
    always_comb
    begin
        a_w  = in_item.first_num[W-1:0];
        b_w  = in_item.first_den[W-1:0];
        c_w  = in_item.second_num[W-1:0];
        d_w  = in_item.second_den[W-1:0];
        ma_w = a_w[W-1] ? W'(-a_w) : W'(a_w);
        mb_w = b_w[W-1] ? W'(-b_w) : W'(b_w);
        mc_w = c_w[W-1] ? W'(-c_w) : W'(c_w);
        md_w = d_w[W-1] ? W'(-d_w) : W'(d_w);
    end

    // Shared multiplier, operands chosen by phase.
    logic [W-1:0]  mul_x, mul_y;
    logic [MW-1:0] mul_p;
    always_comb
    begin
        if (cmd.mul2)
        begin
            mul_x = mc_reg;
            mul_y = mb_reg;
        end
        else
        begin
            mul_x = mb_reg;
            mul_y = md_reg;
        end
        mul_p = MW'(mul_x) * MW'(mul_y);
    end

    // Combine the cross products into a sign and magnitude; in normalize mode the first fraction passes through.
    logic          scx;
    logic [MW-1:0] mag_c;
    logic          neg_c;
    logic [MW-1:0] num_src, den_src;
    always_comb
    begin
        scx = (act_reg == ACT_SUB) ? ~sc_reg : sc_reg;
        if (sa_reg == scx)
        begin
            mag_c = p_reg + q_reg;
            neg_c = sa_reg;
        end
        else if (p_reg >= q_reg)
        begin
            mag_c = p_reg - q_reg;
            neg_c = sa_reg;
        end
        else
        begin
            mag_c = q_reg - p_reg;
            neg_c = scx;
        end
        if (act_reg == ACT_NORM)
        begin
            num_src = MW'(ma_reg);
            den_src = MW'(mb_reg);
            neg_c   = sa_reg;
        end
        else
        begin
            num_src = mag_c;
            den_src = den_reg;
        end
    end

    // Binary GCD step.
    logic          g_done;
    logic [MW-1:0] g_diff;
    always_comb
    begin
        g_done = (gx_reg == '0) || (gy_reg == '0);
        g_diff = (gx_reg >= gy_reg) ? gx_reg - gy_reg : gy_reg - gx_reg;
    end

    // Restoring divide step for both quotients.
    logic [MW-1:0] rn_sh, rd_sh;
    logic          tn, td;
    always_comb
    begin
        rn_sh = {rn_reg[MW-2:0], qn_reg[MW-1]};
        rd_sh = {rd_reg[MW-2:0], qd_reg[MW-1]};
        tn = rn_sh >= dv_reg;
        td = rd_sh >= dv_reg;
    end

    // Overflow check on the reduced quotients.
    logic [MW-1:0] lim;
    logic          ovf;
    always_comb
    begin
        lim = neg_reg ? (MW'(1) << (W - 1)) : (MW'(1) << (W - 1)) - MW'(1);
        ovf = (qn_reg > lim) || (qd_reg > (MW'(1) << (W - 1)) - MW'(1));
    end

    // Results known without reduction, and the final result word.
    logic     early_next;
    ras_out_t early_out_next;
    ras_out_t out_next;
    always_comb
    begin
        early_next     = 1'b1;
        early_out_next = '0;
        if (zero_reg)
            early_out_next.status = ST_ZERO_DEN;
        else if (act_reg == ACT_EQ)
            early_out_next.is_equal = (p_reg == q_reg) &&
                                      (p_reg == '0 || sa_reg == sc_reg);
        else if (num_src == '0)
            early_out_next.result_den = 31'd1;
        else
            early_next = 1'b0;

        out_next = '0;
        if (early_reg)
            out_next = early_out_reg;
        else if (ovf)
            out_next.status = ST_OVERFLOW;
        else
        begin
            out_next.result_num = 32'(signed'(neg_reg ? W'(-qn_reg[W-1:0])
                                                      : qn_reg[W-1:0]));
            out_next.result_den = 31'(qd_reg[W-2:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= in_item.action;
            ma_reg   <= ma_w;
            mb_reg   <= mb_w;
            mc_reg   <= mc_w;
            md_reg   <= md_w;
            sa_reg   <= a_w[W-1] ^ b_w[W-1];
            sc_reg   <= c_w[W-1] ^ d_w[W-1];
            zero_reg <= (b_w == '0) || (in_item.action != ACT_NORM && d_w == '0);
            p_reg    <= MW'(ma_w) * MW'(md_w);
        end
        if (cmd.mul2)
            q_reg <= mul_p;
        if (cmd.mul3)
            den_reg <= mul_p;
        if (cmd.combine)
        begin
            mag_reg <= num_src;
            den_reg <= den_src;
            neg_reg <= neg_c;
            gx_reg  <= num_src;
            gy_reg  <= den_src;
            gk_reg  <= '0;
            early_reg     <= early_next;
            early_out_reg <= early_out_next;
        end
        if (cmd.gcd_step)
        begin
            if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + CW'(1);
            end
            else if (!gx_reg[0])
                gx_reg <= gx_reg >> 1;
            else if (!gy_reg[0])
                gy_reg <= gy_reg >> 1;
            else if (gx_reg >= gy_reg)
                gx_reg <= g_diff >> 1;
            else
                gy_reg <= g_diff >> 1;
        end
        if (cmd.finish)
        begin
            dv_reg   <= (gx_reg | gy_reg) << gk_reg;
            qn_reg   <= mag_reg;
            qd_reg   <= den_reg;
            rn_reg   <= '0;
            rd_reg   <= '0;
            dcnt_reg <= CW'(MW);
        end
        if (cmd.div_step)
        begin
            rn_reg   <= tn ? rn_sh - dv_reg : rn_sh;
            rd_reg   <= td ? rd_sh - dv_reg : rd_sh;
            qn_reg   <= {qn_reg[MW-2:0], tn};
            qd_reg   <= {qd_reg[MW-2:0], td};
            dcnt_reg <= dcnt_reg - CW'(1);
        end
        if (cmd.emit)
            out_reg <= out_next;
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit;
    end

    assign stat.early    = early_reg;
    assign stat.gcd_done = g_done;
    assign stat.div_done = (dcnt_reg == '0);
    assign strobe        = strobe_reg;
    assign out_item      = out_reg;

endmodule

[rtl/ras_checker.sv]
// Port-level checker for the rational block, bound to the top level.
// Uses ras_pkg.
module ras_checker
    import ras_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input ras_out_t out_item
);

    // A transfer always makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("no busy after transfer");

    // A result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");

    // The result comes as the block leaves busy.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy)) else $error("done while busy");

    // A non-ok status carries a zero fraction.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_item.status != ST_OK |->
        out_item.result_num == '0 && out_item.result_den == '0)
        else $error("error result not zero");

endmodule

bind rational_add_sub_normalize ras_checker u_ras_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .out_item (out_item)
);
